@@ hw/rtl/hevc_intra_predictor_macros.svh @@
// Assertion macros for the intra predictor.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HEVC_INTRA_PREDICTOR_MACROS_SVH
`define HEVC_INTRA_PREDICTOR_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define HIP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("intra predictor check failed");
// Consequent must hold in the cycle after the antecedent.
`define HIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("intra predictor check failed");
`endif

@@ hw/rtl/hip_pkg.sv @@
// Shared types, constants and mode tables of the intra predictor.
// No dependencies.
package hip_pkg;

  localparam int MAX_BLOCK   = 32;
  localparam int SAMPLE_BITS = 10;
  localparam int REF_DEPTH   = 2 * MAX_BLOCK;
  localparam int REF_AW      = $clog2(REF_DEPTH);
  localparam int LG_MIN      = 2;
  localparam int LG_MAX      = $clog2(MAX_BLOCK);
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam logic       OP_LOAD     = 1'b0;
  localparam logic       OP_PRED     = 1'b1;
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_TOP    = 2'd1;
  localparam logic [1:0] SIDE_CORNER = 2'd2;

  localparam logic [5:0] MODE_PLANAR = 6'd0;
  localparam logic [5:0] MODE_DC     = 6'd1;
  localparam logic [5:0] MODE_HOR    = 6'd10;
  localparam logic [5:0] MODE_VER    = 6'd26;
  localparam logic [5:0] MODE_DIAG   = 6'd18;
  localparam logic [5:0] MODE_LAST   = 6'd34;
  localparam logic [5:0] MODE_NEG_LO = 6'd11;
  localparam logic [5:0] MODE_NEG_HI = 6'd25;

  localparam logic CFG_LUMA_BD   = 1'b0;
  localparam logic CFG_CHROMA_BD = 1'b1;

  typedef enum logic [1:0] {
    K_LEFT   = 2'd0,
    K_TOP    = 2'd1,
    K_CORNER = 2'd2,
    K_PRED   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] ref_side;
    logic [5:0] ref_index;
    logic [9:0] ref_value;
    logic [5:0] pred_mode;
    logic [2:0] log2_size;
    logic       is_luma;
    logic [4:0] row;
  } in_t;

  typedef struct packed {
    logic [4:0] column;
    logic [9:0] sample;
    logic       last;
  } out_t;

  typedef struct packed {
    kind_t                  kind;
    logic [REF_AW-1:0]      idx;
    logic [SAMPLE_BITS-1:0] value;
    logic [5:0]             mode;
    logic [2:0]             lg;
    logic                   luma;
    logic [4:0]             row;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic signed [6:0] angle_of(input logic [5:0] mode);
    logic signed [6:0] a;
    case (mode)
      6'd2:  a = 7'sd32;   6'd3:  a = 7'sd26;   6'd4:  a = 7'sd21;
      6'd5:  a = 7'sd17;   6'd6:  a = 7'sd13;   6'd7:  a = 7'sd9;
      6'd8:  a = 7'sd5;    6'd9:  a = 7'sd2;    6'd10: a = 7'sd0;
      6'd11: a = -7'sd2;   6'd12: a = -7'sd5;   6'd13: a = -7'sd9;
      6'd14: a = -7'sd13;  6'd15: a = -7'sd17;  6'd16: a = -7'sd21;
      6'd17: a = -7'sd26;  6'd18: a = -7'sd32;  6'd19: a = -7'sd26;
      6'd20: a = -7'sd21;  6'd21: a = -7'sd17;  6'd22: a = -7'sd13;
      6'd23: a = -7'sd9;   6'd24: a = -7'sd5;   6'd25: a = -7'sd2;
      6'd26: a = 7'sd0;    6'd27: a = 7'sd2;    6'd28: a = 7'sd5;
      6'd29: a = 7'sd9;    6'd30: a = 7'sd13;   6'd31: a = 7'sd17;
      6'd32: a = 7'sd21;   6'd33: a = 7'sd26;   6'd34: a = 7'sd32;
      default: a = 7'sd0;
    endcase
    return a;
  endfunction

  function automatic logic [12:0] inv_of(input logic [5:0] mode);
    logic [12:0] v;
    case (mode)
      6'd11, 6'd25: v = 13'd4096;
      6'd12, 6'd24: v = 13'd1638;
      6'd13, 6'd23: v = 13'd910;
      6'd14, 6'd22: v = 13'd630;
      6'd15, 6'd21: v = 13'd482;
      6'd16, 6'd20: v = 13'd390;
      6'd17, 6'd19: v = 13'd315;
      6'd18:        v = 13'd256;
      default:      v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/hevc_intra_predictor.sv @@
// Top level of the intra sample predictor: configuration registers,
// front end, command queue and back end. Depends on hip_pkg and the macros.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one word per
// accepted cycle. A load word writes one reference sample into the left
// store, the top store or the corner register; a predict word names mode,
// size, luma flag and row and yields that row's samples on the output
// channel (out_valid, out_stall, out_data), one word per column, left to
// right, with last set on the final column.
// The back end pops no new command until the current row has drained
// from the column pipeline; for DC mode it first sums both reference edges
// one entry per cycle through the store read ports. A load word is written
// as it leaves the queue. Samples pass the column pipeline and an output
// register. A two-entry command queue keeps the input open while a row runs.
// When the receiver stalls, the output word holds and the column pipeline
// freezes; once the queue fills, in_stall rises. Synchronous reset clears
// the queue, the pipeline, the corner sample and sets both bit depths to
// 8; the left and top stores must be loaded before they are read.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
`include "hevc_intra_predictor_macros.svh"
module hevc_intra_predictor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hip_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hip_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data
);

  logic [3:0]       luma_bd_r, chroma_bd_r;
  logic             push, q_full, pop;
  hip_pkg::cmd_t    push_cmd;
  hip_pkg::q_head_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_bd_r   <= 4'd8;
      chroma_bd_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        hip_pkg::CFG_LUMA_BD:   luma_bd_r   <= cfg_data;
        hip_pkg::CFG_CHROMA_BD: chroma_bd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hip_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hip_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  hip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .luma_bd   (luma_bd_r),
    .chroma_bd (chroma_bd_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Columns of a row come out back to back, without gaps or skips.
  `HIP_ASSERT_NEXT(a_row_no_gap, out_valid && !out_stall && !out_data.last, out_valid)
  `HIP_ASSERT_NEXT(a_row_next_col, out_valid && !out_stall && !out_data.last, out_data.column == 5'($past(out_data.column) + 5'd1))
  `HIP_ASSERT_SAME(a_last_col, out_valid && out_data.last, out_data.column == 5'd3 || out_data.column == 5'd7 || out_data.column == 5'd15 || out_data.column == 5'd31)

endmodule

@@ hw/rtl/hip_front.sv @@
// Front end: accepts input words, normalizes size and row, and turns
// each in-range one into a queue command. Depends on hip_pkg.
module hip_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  hip_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          push,
  output hip_pkg::cmd_t push_cmd
);

  logic [2:0] lg;
  logic [4:0] row_mask;
  logic       drop;

  always_comb begin
    if (in_data.log2_size < 3'(hip_pkg::LG_MIN)) begin
      lg = 3'(hip_pkg::LG_MIN);
    end else if (in_data.log2_size > 3'(hip_pkg::LG_MAX)) begin
      lg = 3'(hip_pkg::LG_MAX);
    end else begin
      lg = in_data.log2_size;
    end
    row_mask = 5'((6'd1 << lg) - 6'd1);

    push_cmd.idx   = in_data.ref_index;
    push_cmd.value = in_data.ref_value;
    push_cmd.mode  = in_data.pred_mode;
    push_cmd.lg    = lg;
    push_cmd.luma  = in_data.is_luma;
    push_cmd.row   = in_data.row & row_mask;

    drop = 1'b0;
    if (in_data.operation == hip_pkg::OP_PRED) begin
      push_cmd.kind = hip_pkg::K_PRED;
      drop = (in_data.pred_mode > hip_pkg::MODE_LAST);
    end else begin
      case (in_data.ref_side)
        hip_pkg::SIDE_LEFT:   push_cmd.kind = hip_pkg::K_LEFT;
        hip_pkg::SIDE_TOP:    push_cmd.kind = hip_pkg::K_TOP;
        hip_pkg::SIDE_CORNER: push_cmd.kind = hip_pkg::K_CORNER;
        default: begin
          push_cmd.kind = hip_pkg::K_CORNER;
          drop = 1'b1;
        end
      endcase
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && !drop;

endmodule

@@ hw/rtl/hip_fifo.sv @@
// Two-entry command queue between front and back end.
// Depends on hip_pkg.
module hip_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hip_pkg::cmd_t    push_cmd,
  output logic             full,
  input  logic             pop,
  output hip_pkg::q_head_t head
);

  localparam int CW = hip_pkg::Q_AW + 1;

  hip_pkg::cmd_t              ent_r [hip_pkg::Q_DEPTH];
  logic [hip_pkg::Q_AW-1:0]   wp_r, wp_nxt;
  logic [hip_pkg::Q_AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(hip_pkg::Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = hip_pkg::Q_AW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = hip_pkg::Q_AW'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/hip_back.sv @@
// Back end: reference stores, DC sum sequencer and the column pipeline
// that predicts one sample per unstalled cycle. Depends on hip_pkg.
module hip_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [3:0]       luma_bd,
  input  logic [3:0]       chroma_bd,
  input  hip_pkg::q_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output hip_pkg::out_t    out_data
);

  localparam int AW = hip_pkg::REF_AW;
  localparam int SW = hip_pkg::SAMPLE_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DCSUM = 5'b00010,
    ST_DCEND = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  hip_pkg::cmd_t cur_r;

  logic [SW-1:0] left_mem [hip_pkg::REF_DEPTH];
  logic [SW-1:0] top_mem  [hip_pkg::REF_DEPTH];
  logic [SW-1:0] l0_r, l1_r, t0_r, t1_r;
  logic [SW-1:0] corner_r;

  logic [4:0]  x_r, dcx_r;
  logic        dc_pend_r;
  logic [16:0] acc_r;

  logic              s1_v_r, s2_v_r, s3_v_r;
  logic [4:0]        s1_x_r, s2_x_r, s3_x_r;
  logic [4:0]        s2_fr_r, s3_fr_r;
  logic signed [7:0] s2_k_r, s3_k_r;
  logic              out_valid_r;
  hip_pkg::out_t     out_r;

  // Per-row derived values.
  logic [4:0]        nm1;
  logic [5:0]        n6;
  logic              filt, hor, is_ang, side_ok, planar;
  logic signed [6:0] ang;
  logic [12:0]       inv;
  logic              adv, rd_en, issue;

  always_comb begin
    n6      = 6'd1 << cur_r.lg;
    nm1     = 5'(n6 - 6'd1);
    filt    = cur_r.luma && (cur_r.lg < 3'(hip_pkg::LG_MAX));
    hor     = cur_r.mode < hip_pkg::MODE_DIAG;
    planar  = cur_r.mode == hip_pkg::MODE_PLANAR;
    is_ang  = (cur_r.mode > hip_pkg::MODE_DC) && (cur_r.mode != hip_pkg::MODE_HOR)
              && (cur_r.mode != hip_pkg::MODE_VER);
    side_ok = (cur_r.mode >= hip_pkg::MODE_NEG_LO) && (cur_r.mode <= hip_pkg::MODE_NEG_HI);
    ang     = hip_pkg::angle_of(cur_r.mode);
    inv     = hip_pkg::inv_of(cur_r.mode);
  end

  assign adv   = !out_valid_r || !out_stall;
  assign issue = (state_r == ST_RUN);
  assign rd_en = adv || (state_r == ST_DCSUM);
  assign pop   = (state_r == ST_IDLE) && head.valid;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && head.cmd.kind == hip_pkg::K_PRED) begin
          state_nxt = (head.cmd.mode == hip_pkg::MODE_DC) ? ST_DCSUM : ST_RUN;
        end
      end
      ST_DCSUM: begin
        if (dcx_r == nm1) begin
          state_nxt = ST_DCEND;
        end
      end
      ST_DCEND: state_nxt = ST_RUN;
      ST_RUN: begin
        if (adv && x_r == nm1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !s3_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      corner_r    <= '0;
      dc_pend_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dc_pend_r <= (state_r == ST_DCSUM);
      if (pop && head.cmd.kind == hip_pkg::K_CORNER) begin
        corner_r <= head.cmd.value;
      end
      if (adv) begin
        s1_v_r      <= issue;
        s2_v_r      <= s1_v_r;
        s3_v_r      <= s2_v_r;
        out_valid_r <= s3_v_r;
      end
    end
  end

  // Row bookkeeping and DC accumulation.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.cmd;
      acc_r <= 17'(17'd1 << head.cmd.lg);
      dcx_r <= '0;
      x_r   <= '0;
    end else begin
      if (state_r == ST_DCSUM) begin
        dcx_r <= 5'(dcx_r + 5'd1);
      end
      if (dc_pend_r) begin
        acc_r <= 17'(acc_r + 17'(l0_r) + 17'(t0_r));
      end
      if (issue && adv) begin
        x_r <= 5'(x_r + 5'd1);
      end
    end
  end

  // Stage 1: angular step and position.
  logic [4:0]         step, pos;
  logic [5:0]         step1;
  logic signed [12:0] asum;
  logic signed [7:0]  k_c;

  always_comb begin
    step  = hor ? s1_x_r : cur_r.row;
    pos   = hor ? cur_r.row : s1_x_r;
    step1 = 6'(step) + 6'd1;
    asum  = $signed({7'd0, step1}) * $signed(13'(ang));
    k_c   = $signed(asum[12:5]) + $signed({3'b000, pos}) + 8'sd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r  <= x_r;
      s2_x_r  <= s1_x_r;
      s2_fr_r <= asum[4:0];
      s2_k_r  <= k_c;
      s3_x_r  <= s2_x_r;
      s3_fr_r <= s2_fr_r;
      s3_k_r  <= s2_k_r;
    end
  end

  // Stage 2: store addresses, including the projected side index.
  logic [5:0]    nk0, nk1;
  logic [18:0]   prod0, prod1;
  logic [AW-1:0] main0, main1, side0, side1;
  logic [AW-1:0] la0, la1, ta0, ta1;
  logic [7:0]    negk;

  always_comb begin
    negk  = 8'(-s2_k_r);
    nk0   = negk[5:0];
    nk1   = 6'(nk0 - 6'd1);
    prod0 = 19'(nk0) * 19'(inv);
    prod1 = 19'(nk1) * 19'(inv);
    side0 = AW'(((prod0 + 19'd128) >> 8) - 19'd1);
    side1 = AW'(((prod1 + 19'd128) >> 8) - 19'd1);
    main0 = AW'(s2_k_r - 8'sd1);
    main1 = AW'(s2_k_r);
    if (state_r == ST_DCSUM) begin
      la0 = AW'(dcx_r);
      ta0 = AW'(dcx_r);
      la1 = '0;
      ta1 = '0;
    end else if (is_ang) begin
      la0 = hor ? main0 : side0;
      la1 = hor ? main1 : side1;
      ta0 = hor ? side0 : main0;
      ta1 = hor ? side1 : main1;
    end else begin
      la0 = AW'(cur_r.row);
      ta0 = AW'(s2_x_r);
      la1 = planar ? AW'(n6) : '0;
      ta1 = planar ? AW'(n6) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cmd.kind == hip_pkg::K_LEFT) begin
      left_mem[head.cmd.idx] <= head.cmd.value;
    end
    if (rd_en) begin
      l0_r <= left_mem[la0];
      l1_r <= left_mem[la1];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cmd.kind == hip_pkg::K_TOP) begin
      top_mem[head.cmd.idx] <= head.cmd.value;
    end
    if (rd_en) begin
      t0_r <= top_mem[ta0];
      t1_r <= top_mem[ta1];
    end
  end

  // Stage 3: sample arithmetic.
  logic [4:0]         xs, ys;
  logic [SW-1:0]      dc, r0, r1, gsrc, gbase, hi, smp;
  logic signed [7:0]  k1;
  logic [15:0]        wacc;
  logic [17:0]        psum;
  logic [11:0]        dsum;
  logic signed [10:0] diff;
  logic signed [11:0] gv;
  logic [3:0]         bd, bde;

  always_comb begin
    xs   = s3_x_r;
    ys   = cur_r.row;
    dc   = SW'(acc_r >> (cur_r.lg + 3'd1));
    k1   = s3_k_r + 8'sd1;

    if (s3_k_r > 8'sd0) begin
      r0 = hor ? l0_r : t0_r;
    end else if (s3_k_r == 8'sd0 || !side_ok) begin
      r0 = corner_r;
    end else begin
      r0 = hor ? t0_r : l0_r;
    end
    if (k1 > 8'sd0) begin
      r1 = hor ? l1_r : t1_r;
    end else if (k1 == 8'sd0 || !side_ok) begin
      r1 = corner_r;
    end else begin
      r1 = hor ? t1_r : l1_r;
    end
    wacc = 16'(6'd32 - 6'(s3_fr_r)) * 16'(r0) + 16'(s3_fr_r) * 16'(r1) + 16'd16;

    psum = 18'(nm1 - xs) * 18'(l0_r) + 18'(6'(xs) + 6'd1) * 18'(t1_r)
         + 18'(nm1 - ys) * 18'(t0_r) + 18'(6'(ys) + 6'd1) * 18'(l1_r) + 18'(n6);

    // Gradient edge: mode 10 runs along the top, mode 26 down the left.
    if (cur_r.mode == hip_pkg::MODE_HOR) begin
      gsrc  = t0_r;
      gbase = l1_r;
    end else begin
      gsrc  = l0_r;
      gbase = t1_r;
    end
    diff = $signed({1'b0, gsrc}) - $signed({1'b0, corner_r});
    gv   = $signed({2'b00, gbase}) + 12'(diff >>> 1);
    bd   = cur_r.luma ? luma_bd : chroma_bd;
    bde  = (bd > 4'(SW)) ? 4'(SW) : bd;
    hi   = SW'((11'd1 << bde) - 11'd1);

    dsum = '0;
    if (planar) begin
      smp = SW'(psum >> (cur_r.lg + 3'd1));
    end else if (cur_r.mode == hip_pkg::MODE_DC) begin
      if (!filt || (xs != 5'd0 && ys != 5'd0)) begin
        smp = dc;
      end else begin
        if (xs == 5'd0 && ys == 5'd0) begin
          dsum = 12'(l1_r) + 12'({dc, 1'b0}) + 12'(t1_r) + 12'd2;
        end else if (ys == 5'd0) begin
          dsum = 12'(t0_r) + 12'(dc) * 12'd3 + 12'd2;
        end else begin
          dsum = 12'(l0_r) + 12'(dc) * 12'd3 + 12'd2;
        end
        smp = SW'(dsum >> 2);
      end
    end else if (!is_ang) begin
      if (filt && ((cur_r.mode == hip_pkg::MODE_HOR) ? (ys == 5'd0) : (xs == 5'd0))) begin
        if (gv < 12'sd0) begin
          smp = '0;
        end else if (gv > $signed({2'b00, hi})) begin
          smp = hi;
        end else begin
          smp = gv[SW-1:0];
        end
      end else begin
        smp = (cur_r.mode == hip_pkg::MODE_HOR) ? l0_r : t0_r;
      end
    end else begin
      smp = SW'(wacc >> 5);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.column <= s3_x_r;
      out_r.sample <= smp;
      out_r.last   <= (s3_x_r == nm1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
